// ===== rtl/core/cled_pkg.sv =====
// shared types and constants for the character lcs edit script unit
package cled_pkg;

  localparam int MaxLen = 32;
  localparam int LenW = $clog2(MaxLen + 1);
  localparam int IdxW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int Dim = MaxLen + 1;
  localparam int TabDepth = Dim * Dim;
  localparam int TabAw = $clog2(TabDepth);
  localparam int EdDepth = 2 * MaxLen;
  localparam int EdAw = $clog2(EdDepth);
  localparam int CntW = $clog2(EdDepth + 1);

  typedef enum logic [1:0] {
    OP_APPEND_A = 2'd0,
    OP_APPEND_B = 2'd1,
    OP_RUN      = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TAG_EQUAL  = 2'd0,
    TAG_DELETE = 2'd1,
    TAG_INSERT = 2'd2,
    TAG_WHOLE  = 2'd3
  } tag_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_INIT,
    ST_FILL_RD,
    ST_FILL_WAIT,
    ST_FILL_WR,
    ST_TR_RD,
    ST_TR_WAIT,
    ST_TR_DEC,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_WHOLE
  } state_t;

endpackage

// ===== rtl/core/cled_ram.sv =====
// generic single-port-write, single-read ram with registered read data
module cled_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/char_lcs_edit_script_unit.sv =====
// character lcs diff: load two strings, fill the lcs table, trace back, emit edits
// steps: an append stores one byte; a run of equal-length strings first compares them byte
//   by byte up to the first mismatch, then clears the table edges, fills each cell with three
//   reads through the single-read table ram, a wait and a write, then traces back one step
//   at a time and emits each edit from the edit ram
// throughput: one transaction at a time, busy high until the last result is out
// reset: lengths, drop flag and control are cleared; the string and table rams
//   need no clearing; results are never stalled by the receiver
module char_lcs_edit_script_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [7:0] ch,
  output logic       strobe,
  output logic [1:0] tag,
  output logic [7:0] ch_res,
  output logic       last,
  output logic       overflow
);

  localparam int LenW = cled_pkg::LenW;
  localparam int IdxW = cled_pkg::IdxW;
  localparam int TabAw = cled_pkg::TabAw;
  localparam int EdAw = cled_pkg::EdAw;
  localparam int CntW = cled_pkg::CntW;

  cled_pkg::state_t state, state_next;

  logic [LenW-1:0] len_a, len_b;
  logic            dropped;
  logic [LenW-1:0] i, j;
  logic [CntW-1:0] count, k;
  logic [5:0]      diag, up, left;

  // ram ports
  logic            a_we, b_we, t_we, e_we;
  logic [IdxW-1:0] a_wa, b_wa, a_ra, b_ra;
  logic [7:0]      a_rd, b_rd;
  logic [TabAw-1:0] t_wa, t_ra;
  logic [5:0]      t_wd, t_rd;
  logic [EdAw-1:0] e_wa, e_ra;
  logic [9:0]      e_wd, e_rd;
  logic [1:0]      rd_step;

  logic accept;
  assign accept = start && !busy;

  function automatic logic [TabAw-1:0] cell_addr(input logic [LenW-1:0] r,
                                                 input logic [LenW-1:0] c);
    logic [TabAw+LenW:0] p;
    p = (TabAw + LenW + 1)'(r) * (TabAw + LenW + 1)'(cled_pkg::Dim) + (TabAw + LenW + 1)'(c);
    return p[TabAw-1:0];
  endfunction

  cled_ram #(.Width(8), .Depth(cled_pkg::MaxLen)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(ch), .raddr(a_ra), .rdata(a_rd));
  cled_ram #(.Width(8), .Depth(cled_pkg::MaxLen)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(ch), .raddr(b_ra), .rdata(b_rd));
  cled_ram #(.Width(6), .Depth(cled_pkg::TabDepth)) u_ram_tab (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  cled_ram #(.Width(10), .Depth(cled_pkg::EdDepth)) u_ram_ed (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));

  logic ch_eq;
  assign ch_eq = (a_rd == b_rd);

  assign a_we = accept && (op == cled_pkg::OP_APPEND_A) && (len_a < LenW'(cled_pkg::MaxLen));
  assign b_we = accept && (op == cled_pkg::OP_APPEND_B) && (len_b < LenW'(cled_pkg::MaxLen));
  assign a_wa = len_a[IdxW-1:0];
  assign b_wa = len_b[IdxW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cled_pkg::ST_IDLE:
        if (accept && op == cled_pkg::OP_RUN) begin
          if (len_a != len_b) state_next = cled_pkg::ST_INIT;
          else if (len_a == '0) state_next = cled_pkg::ST_WHOLE;
          else state_next = cled_pkg::ST_CMP_RD;
        end
      cled_pkg::ST_CMP_RD: state_next = cled_pkg::ST_CMP_CHK;
      cled_pkg::ST_CMP_CHK:
        if (!ch_eq) state_next = cled_pkg::ST_INIT;
        else if (i == len_a - LenW'(1)) state_next = cled_pkg::ST_WHOLE;
        else state_next = cled_pkg::ST_CMP_RD;
      cled_pkg::ST_INIT:
        if (i >= len_a && j >= len_b) begin
          state_next = (len_a == '0 || len_b == '0) ? cled_pkg::ST_TR_RD : cled_pkg::ST_FILL_RD;
        end
      cled_pkg::ST_FILL_RD: state_next = (rd_step == 2'd2) ? cled_pkg::ST_FILL_WAIT
                                                            : cled_pkg::ST_FILL_RD;
      cled_pkg::ST_FILL_WAIT: state_next = cled_pkg::ST_FILL_WR;
      cled_pkg::ST_FILL_WR:
        if (i == len_a && j == len_b) state_next = cled_pkg::ST_TR_RD;
        else state_next = cled_pkg::ST_FILL_RD;
      cled_pkg::ST_TR_RD:
        if (i == '0 && j == '0) state_next = cled_pkg::ST_EMIT_RD;
        else state_next = (rd_step == 2'd1) ? cled_pkg::ST_TR_WAIT : cled_pkg::ST_TR_RD;
      cled_pkg::ST_TR_WAIT: state_next = cled_pkg::ST_TR_DEC;
      cled_pkg::ST_TR_DEC: state_next = cled_pkg::ST_TR_RD;
      cled_pkg::ST_EMIT_RD: state_next = cled_pkg::ST_EMIT_OUT;
      cled_pkg::ST_EMIT_OUT:
        state_next = (k == CntW'(1)) ? cled_pkg::ST_IDLE : cled_pkg::ST_EMIT_RD;
      cled_pkg::ST_WHOLE: state_next = cled_pkg::ST_IDLE;
      default: state_next = cled_pkg::ST_IDLE;
    endcase
  end

  // memory addressing and outputs
  always_comb begin
    a_ra = '0;
    b_ra = '0;
    t_ra = '0;
    t_we = 1'b0;
    t_wa = '0;
    t_wd = '0;
    e_we = 1'b0;
    e_wa = count[EdAw-1:0];
    e_wd = '0;
    e_ra = '0;
    busy = (state != cled_pkg::ST_IDLE);
    strobe = 1'b0;
    tag = cled_pkg::TAG_WHOLE;
    ch_res = '0;
    last = 1'b0;
    overflow = dropped;
    case (state)
      cled_pkg::ST_CMP_RD: begin
        a_ra = i[IdxW-1:0];
        b_ra = i[IdxW-1:0];
      end
      cled_pkg::ST_INIT: begin
        t_we = 1'b1;
        if (i <= len_a) t_wa = cell_addr(i, '0);
        else t_wa = cell_addr('0, j);
      end
      cled_pkg::ST_FILL_RD, cled_pkg::ST_FILL_WAIT: begin
        // three reads: diagonal, up, left; chars held through the wait for the write
        a_ra = IdxW'(i - LenW'(1));
        b_ra = IdxW'(j - LenW'(1));
        if (state == cled_pkg::ST_FILL_RD) begin
          case (rd_step)
            2'd0: t_ra = cell_addr(i - LenW'(1), j - LenW'(1));
            2'd1: t_ra = cell_addr(i - LenW'(1), j);
            default: t_ra = cell_addr(i, j - LenW'(1));
          endcase
        end
      end
      cled_pkg::ST_FILL_WR: begin
        t_we = 1'b1;
        t_wa = cell_addr(i, j);
        if (ch_eq) t_wd = diag + 6'd1;
        else t_wd = (up > left) ? up : left;
      end
      cled_pkg::ST_TR_RD, cled_pkg::ST_TR_WAIT: begin
        // left cell and chars are read again in the wait so they arrive for the decision
        a_ra = IdxW'(i - LenW'(1));
        b_ra = IdxW'(j - LenW'(1));
        if (state == cled_pkg::ST_TR_RD && rd_step == 2'd0) t_ra = cell_addr(i - LenW'(1), j);
        else t_ra = cell_addr(i, j - LenW'(1));
      end
      cled_pkg::ST_TR_DEC: begin
        e_we = 1'b1;
        if (i != '0 && j != '0) begin
          if (ch_eq) e_wd = {cled_pkg::TAG_EQUAL, a_rd};
          else if (up >= t_rd) e_wd = {cled_pkg::TAG_DELETE, a_rd};
          else e_wd = {cled_pkg::TAG_INSERT, b_rd};
        end else if (i != '0) begin
          e_wd = {cled_pkg::TAG_DELETE, a_rd};
        end else begin
          e_wd = {cled_pkg::TAG_INSERT, b_rd};
        end
      end
      cled_pkg::ST_EMIT_RD: e_ra = EdAw'(k - CntW'(1));
      cled_pkg::ST_EMIT_OUT: begin
        strobe = 1'b1;
        tag = e_rd[9:8];
        ch_res = e_rd[7:0];
        last = (k == CntW'(1));
      end
      cled_pkg::ST_WHOLE: begin
        strobe = 1'b1;
        last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cled_pkg::ST_IDLE;
      len_a <= '0;
      len_b <= '0;
      dropped <= 1'b0;
      rd_step <= '0;
    end else begin
      state <= state_next;
      if (a_we) len_a <= len_a + LenW'(1);
      if (b_we) len_b <= len_b + LenW'(1);
      if (accept && (op == cled_pkg::OP_APPEND_A || op == cled_pkg::OP_APPEND_B)
          && !a_we && !b_we) dropped <= 1'b1;
      if ((state == cled_pkg::ST_FILL_RD || state == cled_pkg::ST_TR_RD)
          && state_next == state) rd_step <= rd_step + 2'd1;
      else rd_step <= '0;
      if (state_next == cled_pkg::ST_IDLE && state != cled_pkg::ST_IDLE) begin
        len_a <= '0;
        len_b <= '0;
        dropped <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      cled_pkg::ST_IDLE: begin
        i <= '0;
        j <= '0;
        count <= '0;
      end
      cled_pkg::ST_CMP_CHK: begin
        // on a mismatch the edge clearing starts from row zero
        if (!ch_eq) i <= '0;
        else i <= i + LenW'(1);
      end
      cled_pkg::ST_INIT: begin
        if (state_next != cled_pkg::ST_INIT) begin
          if (len_a == '0 || len_b == '0) begin
            i <= len_a;
            j <= len_b;
          end else begin
            i <= LenW'(1);
            j <= LenW'(1);
          end
        end else if (i <= len_a) begin
          i <= i + LenW'(1);
          if (i == len_a) j <= '0;
        end else begin
          j <= j + LenW'(1);
        end
      end
      cled_pkg::ST_FILL_RD: begin
        if (rd_step == 2'd1) diag <= t_rd;
        else if (rd_step == 2'd2) up <= t_rd;
      end
      cled_pkg::ST_FILL_WAIT: left <= t_rd;
      cled_pkg::ST_FILL_WR: begin
        if (j == len_b) begin
          j <= LenW'(1);
          i <= i + LenW'(1);
        end else begin
          j <= j + LenW'(1);
        end
        if (i == len_a && j == len_b) begin
          i <= len_a;
          j <= len_b;
        end
      end
      cled_pkg::ST_TR_RD: if (rd_step == 2'd1) up <= t_rd;
      cled_pkg::ST_TR_DEC: begin
        count <= count + CntW'(1);
        if (i != '0 && j != '0) begin
          if (ch_eq) begin
            i <= i - LenW'(1);
            j <= j - LenW'(1);
          end else if (up >= t_rd) i <= i - LenW'(1);
          else j <= j - LenW'(1);
        end else if (i != '0) i <= i - LenW'(1);
        else j <= j - LenW'(1);
      end
      cled_pkg::ST_EMIT_OUT: k <= k - CntW'(1);
      default: ;
    endcase
    if (state == cled_pkg::ST_TR_RD && i == '0 && j == '0) k <= count;
  end

  // the fill pipeline: read step 0 issues diag, step 1 issues up (diag arrives),
  // step 2 issues left (up arrives), wait (left arrives)

  a_busy_run: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result outside a run");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy) else $error("busy after last result");
  a_whole_char: assert property (@(posedge clk) disable iff (rst)
    (strobe && tag == cled_pkg::TAG_WHOLE) |-> (ch_res == 8'd0 && last))
    else $error("bad whole-equal result");

endmodule

// ===== sim/tb_top.sv =====
// testbench for the character lcs edit script unit: table-driven directed part, then random strings
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] tag;
    logic [7:0] ch_res;
    logic       last;
    logic       overflow;
  } edit_t;

  typedef struct {
    cled_pkg::op_t op;
    logic [7:0]    ch;
    logic          typed;      // expected result typed into the row
    edit_t         exp_edit;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] op = cled_pkg::OP_NONE;
  logic [7:0] ch = 8'd0;
  logic       busy, strobe, last, overflow;
  logic [1:0] tag;
  logic [7:0] ch_res;

  char_lcs_edit_script_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .ch(ch),
    .strobe(strobe), .tag(tag), .ch_res(ch_res), .last(last), .overflow(overflow)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [7:0] str_a [cled_pkg::MaxLen];
  logic [7:0] str_b [cled_pkg::MaxLen];
  int         len_a = 0, len_b = 0;
  logic       dropped = 1'b0;
  edit_t      edits_pending [$];
  int         errors = 0;
  int         idle_cycles = 0;
  bit         done = 1'b0;
  row_t       rows [$];

  function automatic void predict_diff();
    int    lcs [cled_pkg::Dim][cled_pkg::Dim];
    edit_t trace [$];
    edit_t e;
    int    i, j;
    bit    same;
    same = (len_a == len_b);
    for (int k = 0; k < len_a && same; k++) if (str_a[k] != str_b[k]) same = 0;
    if (same) begin
      e = '{cled_pkg::TAG_WHOLE, 8'd0, 1'b1, dropped};
      edits_pending.push_back(e);
      return;
    end
    for (i = 0; i <= len_a; i++) lcs[i][0] = 0;
    for (j = 0; j <= len_b; j++) lcs[0][j] = 0;
    for (i = 1; i <= len_a; i++)
      for (j = 1; j <= len_b; j++)
        if (str_a[i-1] == str_b[j-1]) lcs[i][j] = lcs[i-1][j-1] + 1;
        else lcs[i][j] = (lcs[i-1][j] > lcs[i][j-1]) ? lcs[i-1][j] : lcs[i][j-1];
    i = len_a;
    j = len_b;
    while (i > 0 || j > 0) begin
      if (i > 0 && j > 0 && str_a[i-1] == str_b[j-1]) begin
        trace.push_front('{cled_pkg::TAG_EQUAL, str_a[i-1], 1'b0, dropped});
        i--; j--;
      end else if (i > 0 && (j == 0 || lcs[i-1][j] >= lcs[i][j-1])) begin
        trace.push_front('{cled_pkg::TAG_DELETE, str_a[i-1], 1'b0, dropped});
        i--;
      end else begin
        trace.push_front('{cled_pkg::TAG_INSERT, str_b[j-1], 1'b0, dropped});
        j--;
      end
    end
    trace[trace.size()-1].last = 1'b1;
    foreach (trace[k]) edits_pending.push_back(trace[k]);
  endfunction

  // returns 1 when the predictor produced the results for this transaction
  function automatic bit predict_item(cled_pkg::op_t o, logic [7:0] c);
    case (o)
      cled_pkg::OP_APPEND_A: if (len_a < cled_pkg::MaxLen) str_a[len_a++] = c;
                             else dropped = 1'b1;
      cled_pkg::OP_APPEND_B: if (len_b < cled_pkg::MaxLen) str_b[len_b++] = c;
                             else dropped = 1'b1;
      cled_pkg::OP_RUN: begin
        predict_diff();
        len_a = 0; len_b = 0; dropped = 1'b0;
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // start stays high after the transaction so a following one can go back to back
  task automatic drive(cled_pkg::op_t o, logic [7:0] c);
    start <= 1'b1;
    op    <= o;
    ch    <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send(cled_pkg::op_t o, logic [7:0] c);
    drive(o, c);
    void'(predict_item(o, c));
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (edits_pending.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && strobe) begin
      edit_t got, want;
      got = '{tag, ch_res, last, overflow};
      if (edits_pending.size() == 0) begin
        $display("%0t: unexpected result tag=%0d ch=%h last=%b ovf=%b",
                 $time, tag, ch_res, last, overflow);
        errors++;
      end else begin
        want = edits_pending.pop_front();
        if (got.tag != want.tag) begin
          $display("%0t: tag expected %0d actual %0d", $time, want.tag, got.tag); errors++;
        end
        if (got.ch_res != want.ch_res) begin
          $display("%0t: ch_res expected %h actual %h", $time, want.ch_res, got.ch_res);
          errors++;
        end
        if (got.last != want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, got.last); errors++;
        end
        if (got.overflow != want.overflow) begin
          $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                   got.overflow);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction and no result
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_row(cled_pkg::op_t o, logic [7:0] c, logic t = 0, edit_t e = '0);
    row_t r;
    r.op = o; r.ch = c; r.typed = t; r.exp_edit = e;
    rows.push_back(r);
  endtask

  task automatic random_string_run();
    int na, nb, mode;
    logic [7:0] base [$];
    mode = $urandom_range(0, 9);
    na = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 8);
    for (int k = 0; k < na; k++) base.push_back(8'($urandom_range(0, 255)));
    // small alphabet keeps matches common
    if (mode < 6) foreach (base[k]) base[k] = 8'h41 + 8'($urandom_range(0, 3));
    for (int k = 0; k < na; k++) begin send(cled_pkg::OP_APPEND_A, base[k]); idle_gap(); end
    nb = (mode == 9) ? na : (($urandom_range(0, 15) == 0) ? $urandom_range(28, 34)
                                                          : $urandom_range(0, 8));
    for (int k = 0; k < nb; k++) begin
      if (mode == 9 || (k < na && $urandom_range(0, 2) != 0))
        send(cled_pkg::OP_APPEND_B, base[k]);
      else if (mode < 6) send(cled_pkg::OP_APPEND_B, 8'h41 + 8'($urandom_range(0, 3)));
      else send(cled_pkg::OP_APPEND_B, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0) send(cled_pkg::OP_NONE, 8'($urandom_range(0, 255)));
      idle_gap();
    end
    send(cled_pkg::OP_RUN, 8'($urandom_range(0, 255)));
    idle_gap();
  endtask

  initial begin
    int sent;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty run, identical, extremes, op 3 ignored, overflow
    add_row(cled_pkg::OP_RUN, 8'hFF, 1, '{cled_pkg::TAG_WHOLE, 8'd0, 1'b1, 1'b0});
    add_row(cled_pkg::OP_APPEND_A, 8'h00);
    add_row(cled_pkg::OP_APPEND_B, 8'h00);
    add_row(cled_pkg::OP_NONE, 8'hAA);
    add_row(cled_pkg::OP_RUN, 8'h00, 1, '{cled_pkg::TAG_WHOLE, 8'd0, 1'b1, 1'b0});
    add_row(cled_pkg::OP_APPEND_A, 8'hFF);
    add_row(cled_pkg::OP_RUN, 8'h55, 1, '{cled_pkg::TAG_DELETE, 8'hFF, 1'b1, 1'b0});
    add_row(cled_pkg::OP_APPEND_B, 8'h80);
    add_row(cled_pkg::OP_RUN, 8'h00, 1, '{cled_pkg::TAG_INSERT, 8'h80, 1'b1, 1'b0});
    add_row(cled_pkg::OP_APPEND_A, 8'h41);
    add_row(cled_pkg::OP_APPEND_A, 8'h42);
    add_row(cled_pkg::OP_APPEND_B, 8'h42);
    add_row(cled_pkg::OP_APPEND_B, 8'h43);
    add_row(cled_pkg::OP_RUN, 8'h00);
    foreach (rows[k]) begin
      if (rows[k].typed) begin
        void'(predict_item(rows[k].op, rows[k].ch));
        edits_pending.delete();
        edits_pending.push_back(rows[k].exp_edit);
        drive(rows[k].op, rows[k].ch);
      end else send(rows[k].op, rows[k].ch);
      wait_drained();
    end
    // full strings plus dropped bytes on both sides
    for (int k = 0; k < cled_pkg::MaxLen + 1; k++) send(cled_pkg::OP_APPEND_A, 8'(k * 7));
    for (int k = 0; k < cled_pkg::MaxLen + 1; k++)
      send(cled_pkg::OP_APPEND_B, 8'(255 - k * 5));
    send(cled_pkg::OP_RUN, 8'h00);
    wait_drained();

    sent = 0;
    while (sent < 20) begin
      random_string_run();
      sent++;
      if (sent % 10 == 0) wait_drained();
    end
    wait_drained();
    repeat (50) @(posedge clk);
    done = 1'b1;
    if (errors == 0 && edits_pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
